// ===== src/sgw_pkg.sv =====
// ----------------------------------------------------------------------------
// sgw_pkg
// Shared types, sizes and codes of the scatter-gather segment walker.
// ----------------------------------------------------------------------------
`default_nettype none

package sgw_pkg;

  // Table and walk limits
  localparam int MAX_DESC = 16;
  localparam int MAX_SEG  = 64;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 24;
  localparam int AVL_W   = 28;
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 5;

  // Derived sizes
  localparam int DESC_AW = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int CNT_W   = $clog2(MAX_DESC + 1);
  localparam int SEG_W   = $clog2(MAX_SEG + 1);
  localparam int ACC_W   = LEN_W + DESC_AW;
  localparam int XW      = (ACC_W > AVL_W) ? ACC_W : AVL_W;
  localparam logic [AVL_W-1:0] AVAIL_MAX = {AVL_W{1'b1}};

  // Configuration port
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CYCLIC_MODE   = REG_IDX_W'(1);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COPY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REWIND = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_SEGMENT = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_DATA = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  desc_index;
    logic [ADDR_W-1:0] desc_source;
    logic [ADDR_W-1:0] desc_target;
    logic [LEN_W-1:0]  desc_length;
    logic [LEN_W-1:0]  request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_source;
    logic [ADDR_W-1:0] seg_target;
    logic [LEN_W-1:0]  seg_length;
    logic [LEN_W-1:0]  total_copied;
    logic [AVL_W-1:0]  avail_bytes;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  // One descriptor as held in the table memory
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] tgt;
    logic [LEN_W-1:0]  len;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // Configuration seen by the walker
  typedef struct packed {
    logic [ECNT_W-1:0] element_count;
    logic              cyclic_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/sgw_ram.sv =====
// ----------------------------------------------------------------------------
// sgw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sgw_regs.sv =====
// ----------------------------------------------------------------------------
// sgw_regs
// APB-style configuration registers: element count and cyclic mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sgw_regs
  import sgw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [ECNT_W-1:0]    ecount_r, ecount_nxt;
  logic                 cyclic_r, cyclic_nxt;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Decode the write
  always_comb begin
    ecount_nxt = ecount_r;
    cyclic_nxt = cyclic_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ELEMENT_COUNT: ecount_nxt = pwdata[ECNT_W-1:0];
        REG_CYCLIC_MODE:   cyclic_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= '0;
      cyclic_r <= 1'b0;
    end else begin
      ecount_r <= ecount_nxt;
      cyclic_r <= cyclic_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ELEMENT_COUNT: prdata = PDATA_W'(ecount_r);
      REG_CYCLIC_MODE:   prdata = PDATA_W'(cyclic_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.element_count = ecount_r;
  assign cfg.cyclic_mode   = cyclic_r;

endmodule

`default_nettype wire

// ===== src/sgw_walker.sv =====
// ----------------------------------------------------------------------------
// sgw_walker
// Descriptor table memory and the sequencer that sums availability and walks
// the descriptors, one segment command per piece.
// ----------------------------------------------------------------------------
`default_nettype none

module sgw_walker
  import sgw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_AVAIL = 3'd2;
  localparam logic [2:0] S_WRD   = 3'd3;
  localparam logic [2:0] S_WEX   = 3'd4;
  localparam logic [2:0] S_WSEG  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [LEN_W-1:0]  prog_r, prog_nxt;
  logic [LEN_W-1:0]  req_r, req_nxt;
  logic [LEN_W-1:0]  copied_r, copied_nxt;
  logic [SEG_W-1:0]  segcnt_r, segcnt_nxt;
  logic [CNT_W-1:0]  sum_idx_r, sum_idx_nxt;
  logic              rdv_r, rdv_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [AVL_W-1:0]  avail_r, avail_nxt;
  logic [STAT_W-1:0] end_st_r, end_st_nxt;
  logic              trunc_r, trunc_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] tgt_r, tgt_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_r, out_nxt;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cur_adv;
  logic [XW-1:0]     rest;
  logic [XW-1:0]     acc_x;
  logic [XW-1:0]     prog_x;
  logic [AVL_W-1:0]  avail_calc;
  logic              out_free;
  logic [LEN_W-1:0]  piece;
  logic              in_xfer;

  logic              ram_we;
  logic [DESC_AW-1:0] ram_waddr;
  desc_t             ram_wdata;
  logic              ram_re;
  logic [DESC_AW-1:0] ram_raddr;
  desc_t             ram_rdata;

  sgw_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MAX_DESC)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Descriptors in use, clipped to the table size
  always_comb begin
    if (32'(cfg.element_count) > 32'(MAX_DESC)) begin
      count = CNT_W'(MAX_DESC);
    end else begin
      count = CNT_W'(cfg.element_count);
    end
  end

  // Step to the next descriptor, wrapping in cyclic mode
  always_comb begin
    if (cfg.cyclic_mode && (cur_r + CNT_W'(1) == count)) begin
      cur_adv = '0;
    end else begin
      cur_adv = cur_r + CNT_W'(1);
    end
  end

  // Availability from the finished sum
  always_comb begin
    acc_x  = XW'(acc_r);
    prog_x = XW'(prog_r);
    if (cfg.cyclic_mode) begin
      rest = acc_x;
    end else if (acc_x > prog_x) begin
      rest = acc_x - prog_x;
    end else begin
      rest = '0;
    end
    if (rest > XW'(AVAIL_MAX)) begin
      avail_calc = AVAIL_MAX;
    end else begin
      avail_calc = rest[AVL_W-1:0];
    end
  end

  assign out_free = !out_vld_r || out_ready;
  assign piece    = (rem_r < req_r) ? rem_r : req_r;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Table write on a descriptor load; reads are issued only outside idle,
  // so a read never meets a write to the same slot
  assign ram_we    = in_xfer && (in_data.action == ACT_WRITE)
                     && (32'(in_data.desc_index) < 32'(MAX_DESC));
  assign ram_waddr = DESC_AW'(in_data.desc_index);
  assign ram_wdata = '{src: in_data.desc_source,
                       tgt: in_data.desc_target,
                       len: in_data.desc_length};

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    prog_nxt     = prog_r;
    req_nxt      = req_r;
    copied_nxt   = copied_r;
    segcnt_nxt   = segcnt_r;
    sum_idx_nxt  = sum_idx_r;
    rdv_nxt      = 1'b0;
    acc_nxt      = acc_r;
    avail_nxt    = avail_r;
    end_st_nxt   = end_st_r;
    trunc_nxt    = trunc_r;
    rem_nxt      = rem_r;
    src_nxt      = src_r;
    tgt_nxt      = tgt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    ram_re       = 1'b0;
    ram_raddr    = cur_r[DESC_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_data.action == ACT_REWIND) begin
            cur_nxt  = '0;
            prog_nxt = '0;
          end else if (in_data.action == ACT_COPY) begin
            req_nxt     = in_data.request_bytes;
            copied_nxt  = '0;
            segcnt_nxt  = '0;
            trunc_nxt   = 1'b0;
            end_st_nxt  = ST_EMPTY;
            acc_nxt     = '0;
            sum_idx_nxt = cfg.cyclic_mode ? '0 : cur_r;
            state_nxt   = S_SUM;
          end else begin
          end
        end
      end

      // Stream lengths out of the table and accumulate them
      S_SUM: begin
        if (rdv_r) begin
          acc_nxt = acc_r + ACC_W'(ram_rdata.len);
        end
        if (sum_idx_r < count) begin
          ram_re      = 1'b1;
          ram_raddr   = sum_idx_r[DESC_AW-1:0];
          rdv_nxt     = 1'b1;
          sum_idx_nxt = sum_idx_r + CNT_W'(1);
        end else if (!rdv_r) begin
          avail_nxt = avail_calc;
          state_nxt = S_AVAIL;
        end
      end

      S_AVAIL: begin
        if (avail_r == '0) begin
          end_st_nxt = ST_NO_DATA;
          state_nxt  = S_FLUSH;
        end else begin
          state_nxt = S_WRD;
        end
      end

      // Loop head: stop checks, then fetch the current descriptor
      S_WRD: begin
        priority if (req_r == '0) begin
          end_st_nxt = ST_EMPTY;
          state_nxt  = S_FLUSH;
        end else if (cur_r >= count) begin
          end_st_nxt = ST_NO_DATA;
          state_nxt  = S_FLUSH;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_WEX;
        end
      end

      // Remaining bytes and segment addresses
      S_WEX: begin
        rem_nxt = ram_rdata.len - prog_r;
        src_nxt = ram_rdata.src + ADDR_W'(prog_r);
        tgt_nxt = ram_rdata.tgt + ADDR_W'(prog_r);
        priority if (!(ram_rdata.len > prog_r)) begin
          cur_nxt    = cur_adv;
          prog_nxt   = '0;
          end_st_nxt = ST_EMPTY;
          state_nxt  = S_FLUSH;
        end else if (32'(segcnt_r) >= 32'(MAX_SEG)) begin
          trunc_nxt = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_WSEG;
        end
      end

      // Emit the previous segment, hold this one until the next step is known
      S_WSEG: begin
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt = 1'b1;
            out_nxt     = pend_r;
          end
          pend_vld_nxt          = 1'b1;
          pend_nxt.seg_source   = src_r;
          pend_nxt.seg_target   = tgt_r;
          pend_nxt.seg_length   = piece;
          pend_nxt.total_copied = copied_r + piece;
          pend_nxt.avail_bytes  = avail_r;
          pend_nxt.status       = ST_SEGMENT;
          pend_nxt.last         = 1'b0;
          copied_nxt = copied_r + piece;
          req_nxt    = req_r - piece;
          segcnt_nxt = segcnt_r + SEG_W'(1);
          if (rem_r <= req_r) begin
            cur_nxt  = cur_adv;
            prog_nxt = '0;
          end else begin
            prog_nxt = prog_r + piece;
          end
          state_nxt = S_WRD;
        end
      end

      // Final result of the request
      S_FLUSH: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt        = pend_r;
            out_nxt.last   = 1'b1;
            out_nxt.status = trunc_r ? ST_TRUNC : ST_SEGMENT;
            pend_vld_nxt   = 1'b0;
          end else begin
            out_nxt.seg_source   = '0;
            out_nxt.seg_target   = '0;
            out_nxt.seg_length   = '0;
            out_nxt.total_copied = '0;
            out_nxt.avail_bytes  = avail_r;
            out_nxt.status       = end_st_r;
            out_nxt.last         = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_r      <= '0;
      prog_r     <= '0;
      rdv_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      prog_r     <= prog_nxt;
      rdv_r      <= rdv_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Working values and payload
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    copied_r  <= copied_nxt;
    segcnt_r  <= segcnt_nxt;
    sum_idx_r <= sum_idx_nxt;
    acc_r     <= acc_nxt;
    avail_r   <= avail_nxt;
    end_st_r  <= end_st_nxt;
    trunc_r   <= trunc_nxt;
    rem_r     <= rem_nxt;
    src_r     <= src_nxt;
    tgt_r     <= tgt_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== src/scatter_gather_segment_walker.sv =====
// Write and rewind transfers may follow back to back.
// A copy request first sums the lengths of the descriptors in use, one read a cycle
// from the single table port, then walks them with a fetch, remainder and emit step
// per segment; an empty descriptor or the segment limit ends the walk at the remainder.
// Segments appear one step behind the walk; result stalls hold the walk.
// Synchronous reset clears index, progress, registers and handshakes, not the table.
// ----------------------------------------------------------------------------
// scatter_gather_segment_walker
// Scatter-gather descriptor table with a walker that splits copy requests
// into segment commands; configuration through an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module scatter_gather_segment_walker
  import sgw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data
);

  cfg_t cfg;

  sgw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgw_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/sgw_checker.sv =====
// ----------------------------------------------------------------------------
// sgw_checker
// Port-level checks on the segment walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgw_checker
  import sgw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A request still in progress blocks new input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken before request finished");

  // Status-only results close the request and carry no bytes
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_DATA || out_data.status == ST_EMPTY)
    |-> out_data.last && out_data.seg_length == '0 && out_data.total_copied == '0)
    else $error("malformed status-only result");

  // Truncation is flagged only on the final result
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TRUNC |-> out_data.last)
    else $error("truncation on a non-final result");

  // Segments carry bytes and a running total that covers them
  a_seg_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_SEGMENT || out_data.status == ST_TRUNC)
    |-> out_data.seg_length != '0 && out_data.total_copied >= out_data.seg_length)
    else $error("empty or inconsistent segment");

endmodule

bind scatter_gather_segment_walker sgw_checker u_sgw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/scatter_gather_segment_walker_test.sv =====
// ----------------------------------------------------------------------------
// scatter_gather_segment_walker_test
// Self-checking bench for the segment walker. It loads descriptors, sets
// the element count and wrap mode over the APB port, and issues copy and
// rewind transfers. A predictor tracks the table, the current descriptor and
// the progress within it, and every result transfer is checked against it.
// ----------------------------------------------------------------------------
module scatter_gather_segment_walker_test;
  import sgw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 430;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;

  // Predicts the segment commands of each copy request and checks results
  class sg_walk_tracker;
    logic [ADDR_W-1:0] src_tab [MAX_DESC];
    logic [ADDR_W-1:0] tgt_tab [MAX_DESC];
    logic [LEN_W-1:0]  len_tab [MAX_DESC];
    logic [ECNT_W-1:0] elem_count;
    logic              wrap_mode;
    logic [ECNT_W-1:0] cur_desc;
    logic [LEN_W-1:0]  progress;
    out_item_t         segments_due [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       truncations;
    int unsigned       no_data_replies;

    function new();
      elem_count      = '0;
      wrap_mode       = 1'b0;
      cur_desc        = '0;
      progress        = '0;
      mismatches      = 0;
      checked         = 0;
      truncations     = 0;
      no_data_replies = 0;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH @%0t: %s", $realtime, msg);
      end
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      if (idx == REG_ELEMENT_COUNT) begin
        elem_count = value[ECNT_W-1:0];
      end else if (idx == REG_CYCLIC_MODE) begin
        wrap_mode = value[0];
      end
    endfunction

    // Move to the start of the next descriptor, wrapping in cyclic mode
    function void step_desc(int unsigned used);
      cur_desc++;
      progress = '0;
      if (wrap_mode && cur_desc == used) begin
        cur_desc = '0;
      end
    endfunction

    // Note an accepted input transfer and queue the results it causes
    function void plan_segments(in_item_t it);
      int unsigned       used;
      int unsigned       req;
      int unsigned       copied;
      int unsigned       rem;
      int unsigned       piece;
      longint unsigned   total;
      logic [AVL_W-1:0]  avail;
      logic [STAT_W-1:0] end_st;
      bit                trunc;
      out_item_t         seg;
      out_item_t         walk [$];
      case (it.action)
        ACT_WRITE: begin
          src_tab[it.desc_index] = it.desc_source;
          tgt_tab[it.desc_index] = it.desc_target;
          len_tab[it.desc_index] = it.desc_length;
        end
        ACT_REWIND: begin
          cur_desc = '0;
          progress = '0;
        end
        ACT_COPY: begin
          used = (elem_count > MAX_DESC) ? MAX_DESC : elem_count;
          // Bytes available: whole ring when cyclic, else the rest from here
          total = 0;
          for (int i = wrap_mode ? 0 : int'(cur_desc); i < int'(used); i++) begin
            total += len_tab[i];
          end
          if (!wrap_mode) begin
            total = (total > progress) ? total - progress : 0;
          end
          avail = (total > AVAIL_MAX) ? AVAIL_MAX : AVL_W'(total);
          if (avail == 0) begin
            seg        = '0;
            seg.status = ST_NO_DATA;
            seg.last   = 1'b1;
            segments_due.push_back(seg);
            return;
          end
          // Walk the descriptors, one segment per piece
          req    = it.request_bytes;
          copied = 0;
          end_st = ST_EMPTY;
          trunc  = 1'b0;
          while (req > 0) begin
            if (cur_desc >= used) begin
              end_st = ST_NO_DATA;
              break;
            end
            rem = (len_tab[cur_desc] > progress) ? len_tab[cur_desc] - progress : 0;
            if (rem == 0) begin
              step_desc(used);
              end_st = ST_EMPTY;
              break;
            end
            if (walk.size() >= MAX_SEG) begin
              trunc = 1'b1;
              break;
            end
            piece            = (rem < req) ? rem : req;
            copied          += piece;
            seg.seg_source   = src_tab[cur_desc] + ADDR_W'(progress);
            seg.seg_target   = tgt_tab[cur_desc] + ADDR_W'(progress);
            seg.seg_length   = LEN_W'(piece);
            seg.total_copied = LEN_W'(copied);
            seg.avail_bytes  = avail;
            seg.status       = ST_SEGMENT;
            seg.last         = 1'b0;
            walk.push_back(seg);
            progress += LEN_W'(piece);
            req      -= piece;
            if (piece == rem) begin
              step_desc(used);
            end
          end
          // Close the request: a bare status, or mark the final segment
          if (walk.size() == 0) begin
            seg             = '0;
            seg.avail_bytes = avail;
            seg.status      = end_st;
            seg.last        = 1'b1;
            walk.push_back(seg);
          end else begin
            seg      = walk.pop_back();
            seg.last = 1'b1;
            if (trunc) begin
              seg.status = ST_TRUNC;
            end
            walk.push_back(seg);
          end
          foreach (walk[k]) begin
            segments_due.push_back(walk[k]);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_segment(out_item_t got);
      out_item_t want;
      string     diffs;
      checked++;
      if (got.status == ST_TRUNC) begin
        truncations++;
      end
      if (got.status == ST_NO_DATA) begin
        no_data_replies++;
      end
      if (segments_due.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: %h", got));
        return;
      end
      want  = segments_due.pop_front();
      diffs = "";
      if (got.seg_source !== want.seg_source) begin
        diffs = {diffs, $sformatf(" seg_source exp %h got %h", want.seg_source, got.seg_source)};
      end
      if (got.seg_target !== want.seg_target) begin
        diffs = {diffs, $sformatf(" seg_target exp %h got %h", want.seg_target, got.seg_target)};
      end
      if (got.seg_length !== want.seg_length) begin
        diffs = {diffs, $sformatf(" seg_length exp %h got %h", want.seg_length, got.seg_length)};
      end
      if (got.total_copied !== want.total_copied) begin
        diffs = {diffs, $sformatf(" total_copied exp %h got %h",
                                  want.total_copied, got.total_copied)};
      end
      if (got.avail_bytes !== want.avail_bytes) begin
        diffs = {diffs, $sformatf(" avail_bytes exp %h got %h",
                                  want.avail_bytes, got.avail_bytes)};
      end
      if (got.status !== want.status) begin
        diffs = {diffs, $sformatf(" status exp %0d got %0d", want.status, got.status)};
      end
      if (got.last !== want.last) begin
        diffs = {diffs, $sformatf(" last exp %0d got %0d", want.last, got.last)};
      end
      if (diffs != "") begin
        note_mismatch({"result", diffs});
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;

  sg_walk_tracker board;
  bit             in_steady;
  bit             out_steady;
  int             items_sent;
  int             settings_used;

  scatter_gather_segment_walker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Set the action and fill every other field with noise
  function automatic in_item_t noise_item(logic [ACT_W-1:0] act);
    in_item_t it;
    it.action        = act;
    it.desc_index    = IDX_W'($urandom_range(0, MAX_DESC - 1));
    it.desc_source   = $urandom();
    it.desc_target   = $urandom();
    it.desc_length   = LEN_W'($urandom());
    it.request_bytes = LEN_W'($urandom());
    return it;
  endfunction

  // Offer one input transfer after a random gap (none when steady); returns at a falling edge
  task automatic push_item(in_item_t it);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.plan_segments(it);
    if (it.action != ACT_UNUSED) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  task automatic write_desc(int idx, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] tgt,
                            logic [LEN_W-1:0] len);
    in_item_t it;
    it             = noise_item(ACT_WRITE);
    it.desc_index  = IDX_W'(idx);
    it.desc_source = src;
    it.desc_target = tgt;
    it.desc_length = len;
    push_item(it);
  endtask

  task automatic copy(logic [LEN_W-1:0] req);
    in_item_t it;
    it               = noise_item(ACT_COPY);
    it.request_bytes = req;
    push_item(it);
  endtask

  // One APB access: setup cycle, then access until pready
  task automatic apb_access(bit wr, logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drain, let the walker go idle, then program and read back both registers
  task automatic set_walk(logic [ECNT_W-1:0] count, bit cyc);
    logic [PDATA_W-1:0] rd;
    in_valid = 1'b0;
    while (board.segments_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_access(1'b1, REG_ELEMENT_COUNT, PDATA_W'(count), rd);
    board.set_reg(REG_ELEMENT_COUNT, PDATA_W'(count));
    apb_access(1'b1, REG_CYCLIC_MODE, PDATA_W'(cyc), rd);
    board.set_reg(REG_CYCLIC_MODE, PDATA_W'(cyc));
    apb_access(1'b0, REG_ELEMENT_COUNT, '0, rd);
    if (rd !== PDATA_W'(count)) begin
      board.note_mismatch($sformatf("element_count read exp %h got %h", count, rd));
    end
    apb_access(1'b0, REG_CYCLIC_MODE, '0, rd);
    if (rd !== PDATA_W'(cyc)) begin
      board.note_mismatch($sformatf("cyclic_mode read exp %h got %h", cyc, rd));
    end
    settings_used++;
  endtask

  // Result side: random stall before each transfer unless steady, then check it
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_segment(out_data);
      @(negedge clk);
    end
  end

  // Give up after too long without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int                phase;
    int                phase_items;
    int                pick;
    logic [ECNT_W-1:0] cnt;
    logic [LEN_W-1:0]  size;
    board         = new();
    items_sent    = 0;
    settings_used = 0;
    in_steady     = 1'b0;
    out_steady    = 1'b0;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // No descriptors in use after reset: nothing available
    copy(LEN_W'(100));

    // Load the whole table: address wrap in slot 0, a zero length, a full length
    write_desc(0, 32'hFFFF_FFF8, 32'h0000_1000, LEN_W'(40));
    write_desc(1, 32'h0000_0000, 32'hFFFF_FFFF, LEN_W'(1));
    for (int i = 2; i < MAX_DESC - 2; i++) begin
      write_desc(i, $urandom(), $urandom(), LEN_W'($urandom_range(1, 40)));
    end
    write_desc(MAX_DESC - 2, $urandom(), $urandom(), '0);
    write_desc(MAX_DESC - 1, $urandom(), $urandom(), '1);

    set_walk(ECNT_W'(MAX_DESC), 1'b0);
    // Zero request, then pieces within slot 0 crossing the address wrap
    copy('0);
    copy(LEN_W'(10));
    copy(LEN_W'(20));
    // Shrink slot 0 below its progress: it now counts as empty
    write_desc(0, 32'hFFFF_FFF8, 32'h0000_1000, LEN_W'(5));
    copy(LEN_W'(50));
    // Walk up to the zero-length slot, then take the full-length slot whole
    copy('1);
    copy('1);
    copy(LEN_W'(1));

    // Cyclic with the index left beyond the count, then a truncated walk
    set_walk(ECNT_W'(4), 1'b1);
    copy(LEN_W'(50));
    push_item(noise_item(ACT_REWIND));
    copy('1);

    // Random phases; the first few take the register extremes
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: set_walk('1, 1'b1);
        1: set_walk('0, 1'b0);
        2: set_walk(ECNT_W'(MAX_DESC), 1'b1);
        3: set_walk(ECNT_W'(1), 1'b0);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            cnt = '0;
          end else if (pick == 1) begin
            cnt = ECNT_W'($urandom_range(MAX_DESC + 1, 31));
          end else begin
            cnt = ECNT_W'($urandom_range(1, MAX_DESC));
          end
          set_walk(cnt, 1'($urandom_range(0, 1)));
        end
      endcase
      phase++;
      in_steady   = ($urandom_range(0, 3) == 0);
      out_steady  = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(15, 40);
      repeat (phase_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Mostly modest requests, some zero, some huge
          pick = $urandom_range(0, 19);
          if (pick < 2)        size = '0;
          else if (pick < 12)  size = LEN_W'($urandom_range(1, 120));
          else if (pick < 16)  size = LEN_W'($urandom_range(121, 4000));
          else if (pick < 18)  size = LEN_W'($urandom());
          else                 size = '1;
          copy(size);
        end else if (pick < 80) begin
          // Mostly short descriptors so that walks wrap and truncate
          pick = $urandom_range(0, 19);
          if (pick < 2)        size = '0;
          else if (pick < 16)  size = LEN_W'($urandom_range(1, 48));
          else if (pick < 19)  size = LEN_W'($urandom());
          else                 size = '1;
          write_desc($urandom_range(0, MAX_DESC - 1), $urandom(), $urandom(), size);
        end else if (pick < 94) begin
          push_item(noise_item(ACT_REWIND));
        end else begin
          push_item(noise_item(ACT_UNUSED));
        end
      end
    end

    // Drain and let the walker settle
    in_valid = 1'b0;
    while (board.segments_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d input transfers under %0d register settings", items_sent,
             settings_used);
    $display("results checked %0d, truncated walks %0d, no-data replies %0d",
             board.checked, board.truncations, board.no_data_replies);
    if (board.mismatches == 0 && board.segments_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sgw_pkg.sv
src/sgw_ram.sv
src/sgw_regs.sv
src/sgw_walker.sv
src/scatter_gather_segment_walker.sv
src/sgw_checker.sv
verif/scatter_gather_segment_walker_test.sv
